// ===== hw/rtl/cc_pkg.sv =====
package cc_pkg;

    // ChaCha constant words ("expand 32-byte k").
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_0     = 3'd0;
    localparam logic [2:0] REG_KEY_1     = 3'd1;
    localparam logic [2:0] REG_KEY_2     = 3'd2;
    localparam logic [2:0] REG_KEY_3     = 3'd3;
    localparam logic [2:0] REG_NONCE_0   = 3'd4;
    localparam logic [2:0] REG_NONCE_1   = 3'd5;
    localparam logic [2:0] REG_COUNTER   = 3'd6;
    localparam logic [2:0] REG_ROUNDS    = 3'd7;

    localparam logic [3:0] ROUNDS_RESET  = 4'd10;

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } cc_in_t;

    // Output word.
    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } cc_out_t;

    // The four state words that one quarter round works on.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } cc_quad_t;

endpackage

// ===== hw/rtl/cc_ram.sv =====
module cc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/cc_half_qr.sv =====
module cc_half_qr
    import cc_pkg::*;
(
    input  logic     second,
    input  cc_quad_t din,
    output cc_quad_t dout
);

    logic [31:0] a_sum;
    logic [31:0] d_mix;
    logic [31:0] c_sum;
    logic [31:0] b_mix;

    // Half of a quarter round: two add, xor, rotate steps. The first half
    // rotates by 16 and 12, the second half by 8 and 7.
    always_comb
    begin
        a_sum = din.a + din.b;
        d_mix = din.d ^ a_sum;
        if (second)
        begin
            dout.d = {d_mix[23:0], d_mix[31:24]};
        end
        else
        begin
            dout.d = {d_mix[15:0], d_mix[31:16]};
        end
        c_sum = din.c + dout.d;
        b_mix = din.b ^ c_sum;
        if (second)
        begin
            dout.b = {b_mix[24:0], b_mix[31:25]};
        end
        else
        begin
            dout.b = {b_mix[19:0], b_mix[31:20]};
        end
        dout.a = a_sum;
        dout.c = c_sum;
    end

endmodule

// ===== hw/rtl/chacha_stream_cipher.sv =====
// ChaCha stream cipher, one message byte per word.
//
// Input channel in_valid/in_ready/in_data carries a message byte and an
// end-of-message flag. Output channel out_valid/out_ready/out_data returns
// the byte XORed with the keystream and the same flag, one word per input.
// The cfg_write/cfg_index/cfg_data port sets key, nonce, initial counter and
// the number of double rounds; write it only while the block is idle.
//
// Inside a keystream block, an accepted byte goes through the XOR state into
// the output register, and the next byte is taken once the block is idle again.
// The first byte of each 64-byte block first builds the block: a load step,
// the double rounds on the shared half-quarter-round unit, the final addition
// into the keystream RAM and a RAM read step.
//
// Reset clears position and block offset, sets the key, nonce and counter
// registers to zero and the double round count to 10. When the receiver
// stalls, the finished byte is held in the output register. One more input
// word is still accepted; it then waits until the output register is free,
// and the input is not ready meanwhile.
module chacha_stream_cipher
    import cc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cc_in_t      in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output cc_out_t     out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_ROUND = 6'b000100,
        S_FINAL = 6'b001000,
        S_FETCH = 6'b010000,
        S_XOR   = 6'b100000
    } cc_state_t;

    cc_state_t   state_reg, state_next;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce0_reg;
    logic [31:0] nonce1_reg, ctr_init_reg;
    logic [3:0]  rounds_reg;

    logic [5:0]  pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] blk_ctr_reg, blk_ctr_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic [3:0]  dr_cnt_reg, dr_cnt_next;
    logic [2:0]  qtr_reg, qtr_next;
    logic        half_reg, half_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] work_reg [16];
    logic [31:0] work_next [16];
    logic        out_valid_reg, out_valid_next;
    cc_out_t     out_data_reg, out_data_next;

    logic [31:0] ctr_sum;
    logic [31:0] ctr_word;
    logic [31:0] init_w [16];
    logic [31:0] tapped [16];
    cc_quad_t    qr_in, qr_out;
    logic        diag;
    logic        in_fire;
    logic        out_load;
    logic        ram_we;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;
    logic [7:0]  ks_byte;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == S_XOR) && (!out_valid_reg || out_ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce0_reg   <= '0;
            nonce1_reg   <= '0;
            ctr_init_reg <= '0;
            rounds_reg   <= ROUNDS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_0:   key0_reg     <= cfg_data;
                REG_KEY_1:   key1_reg     <= cfg_data;
                REG_KEY_2:   key2_reg     <= cfg_data;
                REG_KEY_3:   key3_reg     <= cfg_data;
                REG_NONCE_0: nonce0_reg   <= cfg_data;
                REG_NONCE_1: nonce1_reg   <= cfg_data[31:0];
                REG_COUNTER: ctr_init_reg <= cfg_data[31:0];
                REG_ROUNDS:  rounds_reg   <= cfg_data[3:0];
                default:     rounds_reg   <= rounds_reg;
            endcase
        end
    end

    // Initial ChaCha state. The load cycle uses the freshly summed counter,
    // the final addition uses the counter kept for this block.
    assign ctr_sum  = ctr_init_reg + offset_reg;
    assign ctr_word = (state_reg == S_LOAD) ? ctr_sum : blk_ctr_reg;

    always_comb
    begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        init_w[4]  = key0_reg[31:0];
        init_w[5]  = key0_reg[63:32];
        init_w[6]  = key1_reg[31:0];
        init_w[7]  = key1_reg[63:32];
        init_w[8]  = key2_reg[31:0];
        init_w[9]  = key2_reg[63:32];
        init_w[10] = key3_reg[31:0];
        init_w[11] = key3_reg[63:32];
        init_w[12] = ctr_word;
        init_w[13] = nonce0_reg[31:0];
        init_w[14] = nonce0_reg[63:32];
        init_w[15] = nonce1_reg;
    end

    // The quarter round always works on the first column (column rounds)
    // or the main diagonal (diagonal rounds). Rotating every row left by
    // one word after each quarter round brings the next column or diagonal
    // to those fixed places; four rotations restore the order.
    assign diag = qtr_reg[2];

    always_comb
    begin
        qr_in.a = work_reg[0];
        if (diag)
        begin
            qr_in.b = work_reg[5];
            qr_in.c = work_reg[10];
            qr_in.d = work_reg[15];
        end
        else
        begin
            qr_in.b = work_reg[4];
            qr_in.c = work_reg[8];
            qr_in.d = work_reg[12];
        end
    end

    cc_half_qr u_half_qr (
        .second (half_reg),
        .din    (qr_in),
        .dout   (qr_out)
    );

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            tapped[i] = work_reg[i];
        end
        tapped[0] = qr_out.a;
        if (diag)
        begin
            tapped[5]  = qr_out.b;
            tapped[10] = qr_out.c;
            tapped[15] = qr_out.d;
        end
        else
        begin
            tapped[4]  = qr_out.b;
            tapped[8]  = qr_out.c;
            tapped[12] = qr_out.d;
        end
    end

    // Keystream RAM write: one word a cycle while the working state shifts.
    assign ram_we    = (state_reg == S_FINAL);
    assign ram_wdata = work_reg[0] + init_w[idx_reg];

    cc_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_ks_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (pos_reg[5:2]),
        .rd_data (ram_rdata)
    );

    // Byte select, little-endian within the keystream word.
    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0:    ks_byte = ram_rdata[7:0];
            2'd1:    ks_byte = ram_rdata[15:8];
            2'd2:    ks_byte = ram_rdata[23:16];
            2'd3:    ks_byte = ram_rdata[31:24];
            default: ks_byte = ram_rdata[7:0];
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        offset_next    = offset_reg;
        blk_ctr_next   = blk_ctr_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        dr_cnt_next    = dr_cnt_reg;
        qtr_next       = qtr_reg;
        half_next      = half_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 16; i++)
        begin
            work_next[i] = work_reg[i];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    data_next = in_data.data_byte;
                    last_next = in_data.message_end;
                    if (pos_reg == 6'd0)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_XOR;
                    end
                end
            end
            S_LOAD:
            begin
                blk_ctr_next = ctr_sum;
                offset_next  = offset_reg + 32'd1;
                for (int i = 0; i < 16; i++)
                begin
                    work_next[i] = init_w[i];
                end
                dr_cnt_next = '0;
                qtr_next    = '0;
                half_next   = 1'b0;
                idx_next    = '0;
                if (rounds_reg == 4'd0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                half_next = !half_reg;
                if (half_reg)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            work_next[r*4 + j] = tapped[r*4 + ((j + 1) % 4)];
                        end
                    end
                    qtr_next = qtr_reg + 3'd1;
                    if (qtr_reg == 3'd7)
                    begin
                        dr_cnt_next = dr_cnt_reg + 4'd1;
                        if (dr_cnt_next == rounds_reg)
                        begin
                            state_next = S_FINAL;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        work_next[i] = tapped[i];
                    end
                end
            end
            S_FINAL:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    work_next[i] = work_reg[i + 1];
                end
                work_next[15] = work_reg[0];
                idx_next      = idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_XOR;
            end
            S_XOR:
            begin
                if (out_load)
                begin
                    out_data_next.result_byte = data_reg ^ ks_byte;
                    out_data_next.result_last = last_reg;
                    out_valid_next            = 1'b1;
                    if (last_reg)
                    begin
                        pos_next    = '0;
                        offset_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            offset_reg    <= '0;
            dr_cnt_reg    <= '0;
            qtr_reg       <= '0;
            half_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            dr_cnt_reg    <= dr_cnt_next;
            qtr_reg       <= qtr_next;
            half_reg      <= half_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        blk_ctr_reg  <= blk_ctr_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 16; i++)
        begin
            work_reg[i] <= work_next[i];
        end
    end

    // An accepted word always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("accepted word did not start processing");

    // The last keystream word is followed by the RAM read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) && (idx_reg == 4'd15) |=> state_reg == S_FETCH)
        else $error("final addition did not end in the read cycle");

    // Building a block advances the block offset by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |=> offset_reg == $past(offset_reg) + 32'd1)
        else $error("block offset did not advance");

    // The end of a message restarts position and block offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && last_reg |=> (pos_reg == 6'd0) && (offset_reg == 32'd0))
        else $error("message end did not restart the keystream");

endmodule

// ===== dv/tb.sv =====
module tb;
    import cc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    cc_in_t      in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    cc_out_t     out_data;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = REG_KEY_0;
    logic [63:0] cfg_data = '0;

    chacha_stream_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the cipher configuration.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] counter_reg;
    logic [3:0]  rounds_reg;

    // Shadow copy of the cipher state.
    logic [31:0] keystream [16];
    logic [31:0] mix [16];
    logic [5:0]  byte_pos;
    logic [31:0] block_ofs;

    // Words waiting to be sent and cipher bytes waiting to come back.
    cc_in_t  plaintext_q [$];
    cc_out_t expected_bytes [$];
    int      queued_count = 0;
    int      accepted_count = 0;
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_round(input int a, input int b, input int c, input int d);
        mix[a] = mix[a] + mix[b];
        mix[d] = rotl32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d];
        mix[b] = rotl32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b];
        mix[d] = rotl32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d];
        mix[b] = rotl32(mix[b] ^ mix[c], 7);
    endfunction

    // Build one 64-byte keystream block for the current block counter.
    function automatic void build_keystream();
        logic [31:0] init [16];
        int i;
        int r;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        init[12] = counter_reg + block_ofs;
        init[13] = nonce_lo_reg[31:0];
        init[14] = nonce_lo_reg[63:32];
        init[15] = nonce_hi_reg;
        for (i = 0; i < 16; i++)
            mix[i] = init[i];
        for (r = 0; r < rounds_reg; r++)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
            keystream[i] = mix[i] + init[i];
    endfunction

    // Cipher one accepted word and advance the position in the message.
    function automatic cc_out_t predict_cipher_byte(input cc_in_t w);
        cc_out_t     r;
        logic [31:0] ks_word;
        if (byte_pos == 6'd0)
        begin
            build_keystream();
            block_ofs = block_ofs + 32'd1;
        end
        ks_word = keystream[byte_pos[5:2]];
        r.result_byte = w.data_byte ^ ks_word[8 * byte_pos[1:0] +: 8];
        r.result_last = w.message_end;
        if (w.message_end)
        begin
            byte_pos = 6'd0;
            block_ofs = 32'd0;
        end
        else
        begin
            byte_pos = byte_pos + 6'd1;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input cc_out_t want,
                                          input cc_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
                     $realtime, what, want.result_byte, want.result_last,
                     got.result_byte, got.result_last);
    endfunction

    // Input driver: valid holds with its word until the block takes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_bytes.push_back(predict_cipher_byte(in_data));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (plaintext_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= plaintext_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        cc_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    note_mismatch("output word with nothing expected", '0, out_data);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.result_byte !== want.result_byte)
                        note_mismatch("result_byte differs", want, out_data);
                    else if (out_data.result_last !== want.result_last)
                        note_mismatch("result_last differs", want, out_data);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_KEY_0:   key_reg[0] = val;
            REG_KEY_1:   key_reg[1] = val;
            REG_KEY_2:   key_reg[2] = val;
            REG_KEY_3:   key_reg[3] = val;
            REG_NONCE_0: nonce_lo_reg = val;
            REG_NONCE_1: nonce_hi_reg = val[31:0];
            REG_COUNTER: counter_reg = val[31:0];
            REG_ROUNDS:  rounds_reg = val[3:0];
            default:     ;
        endcase
    endtask

    task automatic apply_setting(input logic [63:0] k0, input logic [63:0] k1,
                                 input logic [63:0] k2, input logic [63:0] k3,
                                 input logic [63:0] n0, input logic [63:0] n1,
                                 input logic [63:0] ctr, input logic [63:0] rounds);
        write_reg(REG_KEY_0, k0);
        write_reg(REG_KEY_1, k1);
        write_reg(REG_KEY_2, k2);
        write_reg(REG_KEY_3, k3);
        write_reg(REG_NONCE_0, n0);
        write_reg(REG_NONCE_1, n1);
        write_reg(REG_COUNTER, ctr);
        write_reg(REG_ROUNDS, rounds);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Round counts lean toward the extremes and the standard ChaCha20 value.
    function automatic logic [63:0] pick_rounds();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(4))
            0:       v[3:0] = 4'd0;
            1:       v[3:0] = 4'd1;
            2:       v[3:0] = 4'd15;
            3:       v[3:0] = ROUNDS_RESET;
            default: v[3:0] = 4'($urandom_range(15));
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic [7:0] b, input logic last);
        cc_in_t w;
        w.data_byte = b;
        w.message_end = last;
        plaintext_q.push_back(w);
        queued_count++;
    endtask

    task automatic queue_message(input int len, input logic closed);
        int i;
        for (i = 0; i < len; i++)
            queue_word(8'($urandom_range(255)), closed && (i == len - 1));
    endtask

    // Mostly short messages, with some that cross one or more block boundaries.
    task automatic queue_random_messages(input int budget, input logic leave_open);
        int len;
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(9))
                0:       len = 64;
                1:       len = $urandom_range(65, 140);
                2, 3:    len = $urandom_range(21, 63);
                default: len = $urandom_range(1, 20);
            endcase
            sent += len;
            queue_message(len, !(leave_open && sent >= budget));
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int s;
        key_reg[0] = '0;
        key_reg[1] = '0;
        key_reg[2] = '0;
        key_reg[3] = '0;
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        counter_reg = '0;
        rounds_reg = ROUNDS_RESET;
        byte_pos = '0;
        block_ofs = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: single-byte messages with the extreme bytes, then a four-byte message.
        queue_word(8'h00, 1'b1);
        queue_word(8'hFF, 1'b1);
        queue_word(8'h55, 1'b0);
        queue_word(8'hAA, 1'b0);
        queue_word(8'h0F, 1'b0);
        queue_word(8'hF0, 1'b1);
        wait_idle();

        // All-ones key, nonce and counter with the largest round count.
        apply_setting('1, '1, '1, '1, '1, '1, '1, '1);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b1);
        wait_idle();

        // No double rounds: the keystream is the input state doubled.
        apply_setting('0, '0, '0, '0, '0, '0, '0, 64'd0);
        queue_message(3, 1'b1);
        wait_idle();

        // Reconfigure in the middle of a block; the current block must be kept.
        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 64'd1);
        queue_message(5, 1'b0);
        wait_idle();
        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {60'h0, ROUNDS_RESET});
        queue_message(4, 1'b1);
        wait_idle();

        // Random traffic under each idling pattern, two settings per pattern.
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            for (s = 0; s < 2; s++)
            begin
                if (p == 0 && s == 0)
                begin
                    // The block counter wraps from all ones to zero inside one message.
                    apply_setting(pick_word(), pick_word(), pick_word(), pick_word(),
                                  pick_word(), pick_word(), {32'h0, 32'hFFFF_FFFF},
                                  {60'h0, ROUNDS_RESET});
                    queue_message(130, 1'b1);
                end
                else
                begin
                    apply_setting(pick_word(), pick_word(), pick_word(), pick_word(),
                                  pick_word(), pick_word(), pick_word(), pick_rounds());
                end
                queue_random_messages(15, $urandom_range(1));
                wait_idle();
            end
        end

        // Let any stray word from a late keystream build show up.
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("chacha_stream_cipher verification clean");
        else
            $display("chacha_stream_cipher verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("chacha_stream_cipher verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cc_pkg.sv
hw/rtl/cc_ram.sv
hw/rtl/cc_half_qr.sv
hw/rtl/chacha_stream_cipher.sv
dv/tb.sv
